@@ rtl/core/lobm_pkg.sv @@
// ----------------------------------------------------------------------------
// Order book matcher package
// Shared codes, widths and types for the order book matching core.
// ----------------------------------------------------------------------------
package lobm_pkg;

   localparam int BOOK_SLOTS_DEF = 32;

   localparam int PRICE_W = 32;
   localparam int QTY_W   = 32;
   localparam int ID_W    = 32;
   localparam int TS_W    = 48;
   localparam int WORD_W  = 1 + PRICE_W + QTY_W + ID_W;

   localparam logic [1:0] MODE_LIMIT  = 2'd0;
   localparam logic [1:0] MODE_MARKET = 2'd1;
   localparam logic [1:0] MODE_CANCEL = 2'd2;

   localparam logic       SIDE_BUY  = 1'b0;
   localparam logic       SIDE_SELL = 1'b1;

   localparam logic       KIND_TRADE    = 1'b0;
   localparam logic       KIND_COMPLETE = 1'b1;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_BOOK_FULL = 2'd2;

   localparam logic [1:0] SCAN_MATCH  = 2'd0;
   localparam logic [1:0] SCAN_CANCEL = 2'd1;
   localparam logic [1:0] SCAN_BID    = 2'd2;
   localparam logic [1:0] SCAN_ASK    = 2'd3;

   typedef struct packed {
      logic               valid;
      logic               side;
      logic [PRICE_W-1:0] price;
      logic [ID_W-1:0]    id;
   } elem_type;

   typedef struct packed {
      logic               hit;
      logic [PRICE_W-1:0] price;
      logic [ID_W-1:0]    id;
   } cand_type;

endpackage

@@ rtl/core/lobm_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module lobm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

@@ rtl/core/lobm_cmp.sv @@
// ----------------------------------------------------------------------------
// Slot compare unit
// Decides whether the slot just read replaces the current scan candidate.
// ----------------------------------------------------------------------------
module lobm_cmp (
   input  logic [1:0]              scan_kind,
   input  logic                    want_side,
   input  logic [lobm_pkg::ID_W-1:0] cancel_id,
   input  lobm_pkg::cand_type      cand,
   input  lobm_pkg::elem_type      elem,
   output logic                    take
);
   import lobm_pkg::*;

   logic better;

   always_comb begin
      if (elem.price == cand.price) begin
         better = elem.id < cand.id;
      end else if (want_side == SIDE_SELL) begin
         better = elem.price < cand.price;
      end else begin
         better = elem.price > cand.price;
      end
   end

   // A cancel takes the first matching slot; every other scan keeps the best one.
   always_comb begin
      if (scan_kind == SCAN_CANCEL) begin
         take = elem.valid && (elem.id == cancel_id) && !cand.hit;
      end else begin
         take = elem.valid && (elem.side == want_side) && (!cand.hit || better);
      end
   end
endmodule

@@ rtl/core/limit_order_book_matcher_core.sv @@
// Sequence: an order scans the slot store for its best match, trades with it and scans
// again until it is filled or nothing crosses; a limit order's remainder is then posted.
// A cancel scans for its id and clears that slot. Both end with a bid scan, an ask scan and
// the completion transfer; a stalled transfer holds the core in its trade or done state.
// Throughput: one item at a time; the next is accepted once the core is back in idle.
// Reset clears the slot valid bits, sequencer and output valid; next order id is one.
// ----------------------------------------------------------------------------
// Order book matcher core
// Price-time priority matching over a slot store, one slot compared per cycle.
// ----------------------------------------------------------------------------
module limit_order_book_matcher_core #(
   parameter int BOOK_SLOTS = lobm_pkg::BOOK_SLOTS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_mode,
   input  logic                        req_side,
   input  logic [lobm_pkg::PRICE_W-1:0] req_price,
   input  logic [lobm_pkg::QTY_W-1:0]  req_quantity,
   input  logic [lobm_pkg::TS_W-1:0]   req_timestamp,
   input  logic [lobm_pkg::ID_W-1:0]   req_cancel_id,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_kind,
   output logic [lobm_pkg::ID_W-1:0]   rsp_order_id,
   output logic [lobm_pkg::ID_W-1:0]   rsp_passive_id,
   output logic [lobm_pkg::PRICE_W-1:0] rsp_price_res,
   output logic [lobm_pkg::QTY_W-1:0]  rsp_quantity_res,
   output logic [lobm_pkg::TS_W-1:0]   rsp_timestamp_res,
   output logic [lobm_pkg::QTY_W-1:0]  rsp_remaining,
   output logic [1:0]                  rsp_status,
   output logic [lobm_pkg::PRICE_W-1:0] rsp_best_bid,
   output logic [lobm_pkg::PRICE_W-1:0] rsp_best_ask,
   output logic [lobm_pkg::PRICE_W-1:0] rsp_mid_price,
   output logic                        rsp_last
);
   import lobm_pkg::*;

   localparam int IDX_W = (BOOK_SLOTS > 1) ? $clog2(BOOK_SLOTS) : 1;
   localparam int CNT_W = $clog2(BOOK_SLOTS + 1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_MATCH  = 3'd2;
   localparam logic [2:0] S_TRADE  = 3'd3;
   localparam logic [2:0] S_POST   = 3'd4;
   localparam logic [2:0] S_CANCEL = 3'd5;
   localparam logic [2:0] S_DONE   = 3'd6;

   logic [2:0]         state_ff, state_in;
   logic [1:0]         mode_ff, mode_in;
   logic               side_ff, side_in;
   logic [PRICE_W-1:0] price_ff, price_in;
   logic [QTY_W-1:0]   qty_ff, qty_in;
   logic [TS_W-1:0]    ts_ff, ts_in;
   logic [ID_W-1:0]    cid_ff, cid_in;
   logic [ID_W-1:0]    oid_ff, oid_in;
   logic [ID_W-1:0]    next_id_ff, next_id_in;
   logic [1:0]         status_ff, status_in;
   logic [BOOK_SLOTS-1:0] valid_ff, valid_in;

   logic [1:0]         kind_ff, kind_in;
   logic               want_ff, want_in;
   logic [CNT_W-1:0]   scan_idx_ff, scan_idx_in;
   logic               rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   cand_type           cand_ff, cand_in;
   logic [IDX_W-1:0]   best_idx_ff, best_idx_in;
   logic [QTY_W-1:0]   best_qty_ff, best_qty_in;
   logic [QTY_W-1:0]   fill_ff, fill_in;
   logic [PRICE_W-1:0] bid_ff, bid_in;
   logic [PRICE_W-1:0] ask_ff, ask_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_kind_ff, rsp_kind_in;
   logic [ID_W-1:0]    rsp_oid_ff, rsp_oid_in;
   logic [ID_W-1:0]    rsp_pid_ff, rsp_pid_in;
   logic [PRICE_W-1:0] rsp_price_ff, rsp_price_in;
   logic [QTY_W-1:0]   rsp_qty_ff, rsp_qty_in;
   logic [TS_W-1:0]    rsp_ts_ff, rsp_ts_in;
   logic [QTY_W-1:0]   rsp_rem_ff, rsp_rem_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [PRICE_W-1:0] rsp_bid_ff, rsp_bid_in;
   logic [PRICE_W-1:0] rsp_ask_ff, rsp_ask_in;
   logic [PRICE_W-1:0] rsp_mid_ff, rsp_mid_in;

   logic               ram_wr_en;
   logic [IDX_W-1:0]   ram_wr_addr;
   logic [WORD_W-1:0]  ram_wr_data;
   logic [WORD_W-1:0]  ram_rd_data;

   elem_type           elem;
   logic               take;
   logic               issue;
   logic               out_free;
   logic               free_found;
   logic [IDX_W-1:0]   free_idx;
   logic               crosses;
   logic [QTY_W-1:0]   qty_left;
   logic [QTY_W-1:0]   rest_left;
   logic [PRICE_W:0]   mid_sum;

   lobm_ram #(
      .WIDTH(WORD_W),
      .DEPTH(BOOK_SLOTS),
      .ADDR_W(IDX_W)
   ) u_slot_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(scan_idx_ff[IDX_W-1:0]),
      .rd_data(ram_rd_data)
   );

   assign elem.valid = valid_ff[rd_idx_ff];
   assign elem.side  = ram_rd_data[WORD_W-1];
   assign elem.price = ram_rd_data[WORD_W-2 -: PRICE_W];
   assign elem.id    = ram_rd_data[ID_W-1:0];

   lobm_cmp u_cmp (
      .scan_kind(kind_ff),
      .want_side(want_ff),
      .cancel_id(cid_ff),
      .cand     (cand_ff),
      .elem     (elem),
      .take     (take)
   );

   // Lowest-numbered free slot for a resting remainder.
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = BOOK_SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   assign issue     = scan_idx_ff != CNT_W'(BOOK_SLOTS);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign qty_left  = qty_ff - fill_ff;
   assign rest_left = best_qty_ff - fill_ff;
   assign mid_sum   = {1'b0, bid_ff} + {1'b0, ask_ff};

   always_comb begin
      if (side_ff == SIDE_BUY) begin
         crosses = !(cand_ff.price > price_ff);
      end else begin
         crosses = !(cand_ff.price < price_ff);
      end
   end

   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      side_in     = side_ff;
      price_in    = price_ff;
      qty_in      = qty_ff;
      ts_in       = ts_ff;
      cid_in      = cid_ff;
      oid_in      = oid_ff;
      next_id_in  = next_id_ff;
      status_in   = status_ff;
      valid_in    = valid_ff;
      kind_in     = kind_ff;
      want_in     = want_ff;
      scan_idx_in = scan_idx_ff;
      rd_vld_in   = 1'b0;
      rd_idx_in   = scan_idx_ff[IDX_W-1:0];
      cand_in     = cand_ff;
      best_idx_in = best_idx_ff;
      best_qty_in = best_qty_ff;
      fill_in     = fill_ff;
      bid_in      = bid_ff;
      ask_in      = ask_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_oid_in    = rsp_oid_ff;
      rsp_pid_in    = rsp_pid_ff;
      rsp_price_in  = rsp_price_ff;
      rsp_qty_in    = rsp_qty_ff;
      rsp_ts_in     = rsp_ts_ff;
      rsp_rem_in    = rsp_rem_ff;
      rsp_status_in = rsp_status_ff;
      rsp_bid_in    = rsp_bid_ff;
      rsp_ask_in    = rsp_ask_ff;
      rsp_mid_in    = rsp_mid_ff;

      ram_wr_en   = 1'b0;
      ram_wr_addr = best_idx_ff;
      ram_wr_data = {~side_ff, cand_ff.price, rest_left, cand_ff.id};

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               mode_in     = req_mode;
               side_in     = req_side;
               price_in    = req_price;
               ts_in       = req_timestamp;
               cid_in      = req_cancel_id;
               status_in   = STATUS_OK;
               scan_idx_in = '0;
               cand_in     = '0;
               if (req_mode == MODE_LIMIT || req_mode == MODE_MARKET) begin
                  qty_in     = req_quantity;
                  oid_in     = next_id_ff;
                  next_id_in = (next_id_ff == '1) ? ID_W'(1) : next_id_ff + ID_W'(1);
                  kind_in    = SCAN_MATCH;
                  want_in    = ~req_side;
                  state_in   = (req_quantity == '0) ? S_POST : S_SCAN;
               end else if (req_mode == MODE_CANCEL) begin
                  qty_in   = '0;
                  oid_in   = req_cancel_id;
                  kind_in  = SCAN_CANCEL;
                  state_in = S_SCAN;
               end else begin
                  qty_in   = '0;
                  oid_in   = '0;
                  kind_in  = SCAN_BID;
                  want_in  = SIDE_BUY;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // The RAM read data arrives in the cycle after its address is issued.
            if (rd_vld_ff && take) begin
               cand_in.hit   = 1'b1;
               cand_in.price = elem.price;
               cand_in.id    = elem.id;
               best_idx_in   = rd_idx_ff;
               best_qty_in   = ram_rd_data[QTY_W+ID_W-1:ID_W];
            end
            if (issue) begin
               rd_vld_in   = 1'b1;
               scan_idx_in = scan_idx_ff + CNT_W'(1);
            end else if (!rd_vld_ff) begin
               scan_idx_in = '0;
               cand_in     = '0;
               unique case (kind_ff)
                  SCAN_MATCH:  state_in = S_MATCH;
                  SCAN_CANCEL: state_in = S_CANCEL;
                  SCAN_BID: begin
                     bid_in  = cand_ff.hit ? cand_ff.price : '0;
                     kind_in = SCAN_ASK;
                     want_in = SIDE_SELL;
                  end
                  SCAN_ASK: begin
                     ask_in   = cand_ff.hit ? cand_ff.price : '0;
                     state_in = S_DONE;
                  end
                  default: state_in = S_DONE;
               endcase
               if (kind_ff == SCAN_MATCH || kind_ff == SCAN_CANCEL) begin
                  cand_in = cand_ff;
               end
            end
         end
         S_MATCH: begin
            if (!cand_ff.hit || (mode_ff == MODE_LIMIT && !crosses)) begin
               state_in = S_POST;
            end else begin
               fill_in  = (qty_ff < best_qty_ff) ? qty_ff : best_qty_ff;
               state_in = S_TRADE;
            end
         end
         S_TRADE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = KIND_TRADE;
               rsp_oid_in    = oid_ff;
               rsp_pid_in    = cand_ff.id;
               rsp_price_in  = cand_ff.price;
               rsp_qty_in    = fill_ff;
               rsp_ts_in     = ts_ff;
               rsp_rem_in    = '0;
               rsp_status_in = STATUS_OK;
               rsp_bid_in    = '0;
               rsp_ask_in    = '0;
               rsp_mid_in    = '0;
               ram_wr_en     = 1'b1;
               if (best_qty_ff == fill_ff) begin
                  valid_in[best_idx_ff] = 1'b0;
               end
               qty_in      = qty_left;
               scan_idx_in = '0;
               cand_in     = '0;
               state_in    = (qty_left == '0) ? S_POST : S_SCAN;
            end
         end
         S_POST: begin
            if (mode_ff == MODE_LIMIT && qty_ff != '0) begin
               if (free_found) begin
                  ram_wr_en          = 1'b1;
                  ram_wr_addr        = free_idx;
                  ram_wr_data        = {side_ff, price_ff, qty_ff, oid_ff};
                  valid_in[free_idx] = 1'b1;
               end else begin
                  status_in = STATUS_BOOK_FULL;
               end
            end
            scan_idx_in = '0;
            cand_in     = '0;
            kind_in     = SCAN_BID;
            want_in     = SIDE_BUY;
            state_in    = S_SCAN;
         end
         S_CANCEL: begin
            if (cand_ff.hit) begin
               valid_in[best_idx_ff] = 1'b0;
            end else begin
               status_in = STATUS_NOT_FOUND;
            end
            cand_in  = '0;
            kind_in  = SCAN_BID;
            want_in  = SIDE_BUY;
            state_in = S_SCAN;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = KIND_COMPLETE;
               rsp_oid_in    = oid_ff;
               rsp_pid_in    = '0;
               rsp_price_in  = '0;
               rsp_qty_in    = '0;
               rsp_ts_in     = ts_ff;
               rsp_rem_in    = qty_ff;
               rsp_status_in = status_ff;
               rsp_bid_in    = bid_ff;
               rsp_ask_in    = ask_ff;
               rsp_mid_in    = (bid_ff == '0 || ask_ff == '0) ? '0 : mid_sum[PRICE_W:1];
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         next_id_ff   <= ID_W'(1);
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
         scan_idx_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         next_id_ff   <= next_id_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_vld_ff    <= rd_vld_in;
         scan_idx_ff  <= scan_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      side_ff       <= side_in;
      price_ff      <= price_in;
      qty_ff        <= qty_in;
      ts_ff         <= ts_in;
      cid_ff        <= cid_in;
      oid_ff        <= oid_in;
      status_ff     <= status_in;
      kind_ff       <= kind_in;
      want_ff       <= want_in;
      rd_idx_ff     <= rd_idx_in;
      cand_ff       <= cand_in;
      best_idx_ff   <= best_idx_in;
      best_qty_ff   <= best_qty_in;
      fill_ff       <= fill_in;
      bid_ff        <= bid_in;
      ask_ff        <= ask_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_oid_ff    <= rsp_oid_in;
      rsp_pid_ff    <= rsp_pid_in;
      rsp_price_ff  <= rsp_price_in;
      rsp_qty_ff    <= rsp_qty_in;
      rsp_ts_ff     <= rsp_ts_in;
      rsp_rem_ff    <= rsp_rem_in;
      rsp_status_ff <= rsp_status_in;
      rsp_bid_ff    <= rsp_bid_in;
      rsp_ask_ff    <= rsp_ask_in;
      rsp_mid_ff    <= rsp_mid_in;
   end

   assign req_ready         = state_ff == S_IDLE;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_order_id      = rsp_oid_ff;
   assign rsp_passive_id    = rsp_pid_ff;
   assign rsp_price_res     = rsp_price_ff;
   assign rsp_quantity_res  = rsp_qty_ff;
   assign rsp_timestamp_res = rsp_ts_ff;
   assign rsp_remaining     = rsp_rem_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_best_bid      = rsp_bid_ff;
   assign rsp_best_ask      = rsp_ask_ff;
   assign rsp_mid_price     = rsp_mid_ff;
   assign rsp_last          = rsp_kind_ff;

`ifndef ASSERT_OFF
   a_next_id_nonzero: assert property (@(posedge clock) disable iff (reset)
      next_id_ff != '0) else $error("order id counter reached zero");

   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> !ram_wr_en) else $error("slot write during a scan");

   a_fill_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_TRADE |-> (fill_ff != '0 && cand_ff.hit))
      else $error("trade without a filled resting order");

   a_trade_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_TRADE) |-> !rsp_last)
      else $error("trade transfer marked as last");
`endif
endmodule
